@@ sv/owb_pkg.sv @@
// shared types, timing defaults and codes for the one-wire bus master
`timescale 1ns / 1ps
package owb_pkg;

  localparam int TIME_W = 10;

  localparam logic [TIME_W-1:0] READ_TAIL_TIME = 10'd55;
  localparam logic [4:0]        PRESENCE_POLLS = 5'd20;

  localparam logic [TIME_W-1:0] DEF_RESET_LOW      = 10'd480;
  localparam logic [TIME_W-1:0] DEF_RESET_HIGH     = 10'd480;
  localparam logic [TIME_W-1:0] DEF_PRESENCE_SMP   = 10'd40;
  localparam logic [TIME_W-1:0] DEF_INIT_LOW       = 10'd3;
  localparam logic [TIME_W-1:0] DEF_WRITE_ZERO_LOW = 10'd53;
  localparam logic [TIME_W-1:0] DEF_SLOT           = 10'd60;
  localparam logic [TIME_W-1:0] DEF_RECOVERY       = 10'd10;
  localparam logic [TIME_W-1:0] DEF_READ_SAMPLE    = 10'd10;

  // register indexes
  localparam logic [2:0] REG_RESET_LOW      = 3'd0;
  localparam logic [2:0] REG_RESET_HIGH     = 3'd1;
  localparam logic [2:0] REG_PRESENCE_SMP   = 3'd2;
  localparam logic [2:0] REG_INIT_LOW       = 3'd3;
  localparam logic [2:0] REG_WRITE_ZERO_LOW = 3'd4;
  localparam logic [2:0] REG_SLOT           = 3'd5;
  localparam logic [2:0] REG_RECOVERY       = 3'd6;
  localparam logic [2:0] REG_READ_SAMPLE    = 3'd7;

  // function codes
  localparam logic [3:0] FN_TICK     = 4'd0;
  localparam logic [3:0] FN_RESET    = 4'd1;
  localparam logic [3:0] FN_PRESENCE = 4'd2;
  localparam logic [3:0] FN_RST_PRES = 4'd3;
  localparam logic [3:0] FN_WBIT     = 4'd4;
  localparam logic [3:0] FN_WBYTE    = 4'd5;
  localparam logic [3:0] FN_RBIT     = 4'd6;
  localparam logic [3:0] FN_R2BITS   = 4'd7;
  localparam logic [3:0] FN_RBYTE    = 4'd8;

  // phase codes
  localparam logic [3:0] PH_IDLE    = 4'd0;
  localparam logic [3:0] PH_RSTLOW  = 4'd1;
  localparam logic [3:0] PH_PSAMPLE = 4'd2;
  localparam logic [3:0] PH_PTAIL   = 4'd3;
  localparam logic [3:0] PH_WRLOW   = 4'd4;
  localparam logic [3:0] PH_WRHIGH  = 4'd5;
  localparam logic [3:0] PH_RDLOW   = 4'd6;
  localparam logic [3:0] PH_RDWAIT  = 4'd7;
  localparam logic [3:0] PH_RDTAIL  = 4'd8;

  typedef struct packed {
    logic [3:0] func;
    logic [7:0] data_byte;
    logic       line_level;
  } in_item_t;

  typedef struct packed {
    logic       drive_low;
    logic       done_res;
    logic [7:0] read_data;
    logic       presence;
    logic       rejected;
  } out_item_t;

  typedef struct packed {
    logic [TIME_W-1:0] reset_low_time;
    logic [TIME_W-1:0] reset_high_time;
    logic [TIME_W-1:0] presence_sample_time;
    logic [TIME_W-1:0] init_low_time;
    logic [TIME_W-1:0] write_zero_low_time;
    logic [TIME_W-1:0] slot_time;
    logic [TIME_W-1:0] recovery_time;
    logic [TIME_W-1:0] read_sample_time;
  } cfg_t;

  typedef struct packed {
    logic [3:0]        phase;
    logic [3:0]        current_command;
    logic [TIME_W-1:0] time_left;
    logic [3:0]        bits_left;
    logic [7:0]        shift_data;
    logic [4:0]        poll_count;
    logic              last_sample;
    logic              bus_drive;
  } state_t;

endpackage

@@ sv/owb_cfg.sv @@
// timing register file with write port
`timescale 1ns / 1ps
module owb_cfg import owb_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wr_en,
  input  logic [2:0]        cfg_index,
  input  logic [TIME_W-1:0] cfg_data,
  output cfg_t              cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.reset_low_time       <= DEF_RESET_LOW;
      cfg.reset_high_time      <= DEF_RESET_HIGH;
      cfg.presence_sample_time <= DEF_PRESENCE_SMP;
      cfg.init_low_time        <= DEF_INIT_LOW;
      cfg.write_zero_low_time  <= DEF_WRITE_ZERO_LOW;
      cfg.slot_time            <= DEF_SLOT;
      cfg.recovery_time        <= DEF_RECOVERY;
      cfg.read_sample_time     <= DEF_READ_SAMPLE;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_RESET_LOW:      cfg.reset_low_time       <= cfg_data;
        REG_RESET_HIGH:     cfg.reset_high_time      <= cfg_data;
        REG_PRESENCE_SMP:   cfg.presence_sample_time <= cfg_data;
        REG_INIT_LOW:       cfg.init_low_time        <= cfg_data;
        REG_WRITE_ZERO_LOW: cfg.write_zero_low_time  <= cfg_data;
        REG_SLOT:           cfg.slot_time            <= cfg_data;
        REG_RECOVERY:       cfg.recovery_time        <= cfg_data;
        REG_READ_SAMPLE:    cfg.read_sample_time     <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

@@ sv/owb_step.sv @@
// next-state and result logic for one item
`timescale 1ns / 1ps
module owb_step import owb_pkg::*; (
  input  state_t    cur,
  input  in_item_t  item,
  input  cfg_t      cfg,
  output state_t    nxt,
  output out_item_t res
);

  function automatic logic [3:0] total_bits(input logic [3:0] cmd);
    logic [3:0] n;
    n = 4'd1;
    if (cmd == FN_WBYTE || cmd == FN_RBYTE) n = 4'd8;
    else if (cmd == FN_R2BITS) n = 4'd2;
    return n;
  endfunction

  function automatic state_t slot_start(input state_t s, input cfg_t c);
    state_t r;
    r = s;
    r.bus_drive = 1'b1;
    if (s.current_command == FN_WBIT || s.current_command == FN_WBYTE) begin
      r.phase     = PH_WRLOW;
      r.time_left = s.shift_data[0] ? c.init_low_time : c.write_zero_low_time;
    end else begin
      r.phase     = PH_RDLOW;
      r.time_left = c.init_low_time;
    end
    return r;
  endfunction

  function automatic state_t presence_start(input state_t s, input cfg_t c);
    state_t r;
    r = s;
    r.bus_drive   = 1'b0;
    r.phase       = PH_PSAMPLE;
    r.time_left   = c.presence_sample_time;
    r.poll_count  = 5'd0;
    r.last_sample = 1'b1;
    return r;
  endfunction

  logic [TIME_W-1:0] ptail;
  logic [3:0]        bits_dec;
  logic [3:0]        rd_idx;
  logic [7:0]        shift_after;
  logic              is_write;
  logic              fin;

  assign ptail = (cfg.reset_high_time > cfg.presence_sample_time) ?
                 (cfg.reset_high_time - cfg.presence_sample_time) : '0;
  assign is_write = (cur.current_command == FN_WBIT) || (cur.current_command == FN_WBYTE);
  assign bits_dec = cur.bits_left - 4'd1;
  assign rd_idx   = total_bits(cur.current_command) - cur.bits_left;
  assign shift_after = is_write ? (cur.shift_data >> 1) : cur.shift_data;

  always_comb begin
    nxt = cur;
    res = '0;
    fin = 1'b0;
    if (item.func inside {[FN_RESET:FN_RBYTE]}) begin
      if (cur.phase != PH_IDLE) begin
        res.rejected = 1'b1;
      end else begin
        nxt.current_command = item.func;
        nxt.shift_data      = 8'd0;
        if (item.func == FN_RESET || item.func == FN_RST_PRES) begin
          nxt.bus_drive = 1'b1;
          nxt.phase     = PH_RSTLOW;
          nxt.time_left = cfg.reset_low_time;
        end else if (item.func == FN_PRESENCE) begin
          nxt = presence_start(nxt, cfg);
        end else begin
          if (item.func == FN_WBIT) nxt.shift_data = {7'd0, item.data_byte[0]};
          else if (item.func == FN_WBYTE) nxt.shift_data = item.data_byte;
          nxt.bits_left = total_bits(item.func);
          nxt = slot_start(nxt, cfg);
        end
      end
    end else if (item.func == FN_TICK && cur.phase != PH_IDLE) begin
      if (cur.time_left > 10'd1) begin
        nxt.time_left = cur.time_left - 10'd1;
      end else begin
        nxt.time_left = '0;
        case (cur.phase)
          PH_RSTLOW: begin
            nxt.bus_drive = 1'b0;
            if (cur.current_command == FN_RESET) fin = 1'b1;
            else nxt = presence_start(nxt, cfg);
          end
          PH_PSAMPLE: begin
            nxt.last_sample = item.line_level;
            if (item.line_level && cur.poll_count < PRESENCE_POLLS) begin
              nxt.poll_count = cur.poll_count + 5'd1;
              nxt.time_left  = cfg.recovery_time;
            end else begin
              nxt.phase     = PH_PTAIL;
              nxt.time_left = ptail;
            end
          end
          PH_PTAIL: begin
            fin          = 1'b1;
            res.presence = ~cur.last_sample;
          end
          PH_WRLOW: begin
            nxt.bus_drive = 1'b0;
            nxt.phase     = PH_WRHIGH;
            nxt.time_left = cur.shift_data[0] ? cfg.slot_time : cfg.recovery_time;
          end
          PH_RDLOW: begin
            nxt.bus_drive = 1'b0;
            nxt.phase     = PH_RDWAIT;
            nxt.time_left = cfg.read_sample_time;
          end
          PH_RDWAIT: begin
            if (item.line_level) nxt.shift_data[rd_idx[2:0]] = 1'b1;
            nxt.phase     = PH_RDTAIL;
            nxt.time_left = READ_TAIL_TIME;
          end
          PH_WRHIGH, PH_RDTAIL: begin
            nxt.bits_left  = bits_dec;
            nxt.shift_data = shift_after;
            if (bits_dec != 4'd0) begin
              nxt = slot_start(nxt, cfg);
            end else begin
              fin = 1'b1;
              if (cur.phase == PH_RDTAIL) res.read_data = shift_after;
            end
          end
          default: fin = 1'b1;
        endcase
        if (fin) begin
          res.done_res  = 1'b1;
          nxt.phase     = PH_IDLE;
          nxt.bus_drive = 1'b0;
          nxt.time_left = '0;
        end
      end
    end
    res.drive_low = nxt.bus_drive;
  end

endmodule

@@ sv/one_wire_bus_master_unit.sv @@
// top level of the standard-speed one-wire bus master
// path: an item is held in the input register, its result in the result register
// throughput: one item per cycle while out_stall is low; the two registers
// separate the two sides so stalls on the output do not block intake at once
// reset: synchronous, clears bus state to idle with the bus released and
// loads the default timings into the configuration registers
`timescale 1ns / 1ps
module one_wire_bus_master_unit import owb_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wr_en,
  input  logic [2:0]        cfg_index,
  input  logic [TIME_W-1:0] cfg_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_item_t          in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output out_item_t         out_data
);

  cfg_t      cfg;
  state_t    state;
  state_t    state_next;
  out_item_t res;
  in_item_t  in_reg;
  logic      in_reg_valid;
  logic      adv;

  owb_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  owb_step u_step (
    .cur  (state),
    .item (in_reg),
    .cfg  (cfg),
    .nxt  (state_next),
    .res  (res)
  );

  assign adv      = ~out_valid | ~out_stall;
  assign in_stall = in_reg_valid & ~adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_reg_valid      <= 1'b0;
      out_valid         <= 1'b0;
      state.phase           <= PH_IDLE;
      state.current_command <= 4'd0;
      state.time_left       <= '0;
      state.bits_left       <= 4'd0;
      state.shift_data      <= 8'd0;
      state.poll_count      <= 5'd0;
      state.last_sample     <= 1'b1;
      state.bus_drive       <= 1'b0;
    end else begin
      if (in_valid && !in_stall) in_reg_valid <= 1'b1;
      else if (adv) in_reg_valid <= 1'b0;
      if (adv && in_reg_valid) begin
        out_valid <= 1'b1;
        state     <= state_next;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) in_reg <= in_data;
    if (adv && in_reg_valid) out_data <= res;
  end

endmodule
